>>> rtl/core/callback_timing_deadline_monitor_macros.svh
// Assertion macros for the deadline monitor checker.
// Both sample on clk and are disabled while arst_n is low.
`ifndef CALLBACK_TIMING_DEADLINE_MONITOR_MACROS_SVH
`define CALLBACK_TIMING_DEADLINE_MONITOR_MACROS_SVH

`define CBTDM_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("deadline monitor check failed: %m");

// Implication into the next cycle.
`define CBTDM_ASSERT_NEXT(name, ante, cons) \
	`CBTDM_ASSERT(name, (ante) |=> (cons))

`endif

>>> rtl/core/cbtdm_pkg.sv
package cbtdm_pkg;

	localparam int TS_W       = 64;
	localparam int CNT_W      = 32;
	localparam int FRAMES_W   = 16;
	localparam int RATE_W     = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam int NS_W = 30;
	localparam logic [NS_W-1:0] NS_PER_SECOND = 30'd1000000000;

	// frames * 1e9 and the quotient both fit here
	localparam int PROD_W    = FRAMES_W + NS_W;
	localparam int THR_W     = PROD_W + 1;
	localparam int DIV_CNT_W = $clog2(PROD_W);

	localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE   = 2'd1;

	localparam logic [FRAMES_W-1:0] FRAMES_RST = 16'd256;
	localparam logic [RATE_W-1:0]   RATE_RST   = 20'd48000;
	localparam logic [CNT_W-1:0]    CNT_MAX    = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_THRESH,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic capture;
		logic prep;
		logic div_step;
		logic thresh;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} sts_t;

endpackage

>>> rtl/core/cbtdm_ctrl.sv
module cbtdm_ctrl import cbtdm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd         = '0;
		in_ready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_THRESH;
				end
			end
			ST_THRESH: begin
				cmd.thresh = 1'b1;
				state_d    = ST_UPDATE;
			end
			ST_UPDATE: begin
				// statistics double as the result, so wait for the slot to drain
				if (!out_valid_q || out_ready) begin
					cmd.update  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/core/cbtdm_dp.sv
module cbtdm_dp import cbtdm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [TS_W-1:0]       start_time,
	input  logic [TS_W-1:0]       finish_time,
	output logic [CNT_W-1:0]      event_count,
	output logic [CNT_W-1:0]      miss_count,
	output logic [TS_W-1:0]       longest_gap,
	output logic [TS_W-1:0]       longest_busy
);

	logic [FRAMES_W-1:0]  frames_q;
	logic [RATE_W-1:0]    rate_q;
	logic [TS_W-1:0]      start_q, finish_q;
	logic [TS_W-1:0]      gap_q, busy_q;
	logic                 gap_ok_q, busy_ok_q;
	logic [PROD_W-1:0]    quot_q;
	logic [RATE_W-1:0]    rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [THR_W-1:0]     thresh_q;
	logic [TS_W-1:0]      last_q, gap_peak_q, busy_peak_q;
	logic [CNT_W-1:0]     events_q, misses_q;

	logic [PROD_W-1:0] prod_c;
	logic [RATE_W:0]   trial_c, diff_c;
	logic              ge_c, miss_c;

	always_comb begin
		prod_c  = PROD_W'(frames_q) * PROD_W'(NS_PER_SECOND);
		trial_c = {rem_q, quot_q[PROD_W-1]};
		diff_c  = trial_c - {1'b0, rate_q};
		ge_c    = trial_c >= {1'b0, rate_q};
		miss_c  = gap_ok_q && (rate_q != '0)
			&& (gap_q > {{(TS_W-THR_W){1'b0}}, thresh_q});
	end

	assign sts.div_last = (cnt_q == DIV_CNT_W'(PROD_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RST;
			rate_q   <= RATE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAMES: frames_q <= cfg_data[FRAMES_W-1:0];
				REG_RATE:   rate_q   <= cfg_data[RATE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// work registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			start_q  <= start_time;
			finish_q <= finish_time;
		end
		if (cmd.prep) begin
			gap_q     <= start_q - last_q;
			gap_ok_q  <= (last_q != '0) && (start_q >= last_q);
			busy_q    <= finish_q - start_q;
			busy_ok_q <= finish_q >= start_q;
			quot_q    <= prod_c;
			rem_q     <= '0;
			cnt_q     <= '0;
		end
		// restoring division, one quotient bit per cycle
		if (cmd.div_step) begin
			rem_q  <= ge_c ? diff_c[RATE_W-1:0] : trial_c[RATE_W-1:0];
			quot_q <= {quot_q[PROD_W-2:0], ge_c};
			cnt_q  <= cnt_q + 1'b1;
		end
		if (cmd.thresh) begin
			thresh_q <= {1'b0, quot_q} + THR_W'(quot_q >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= '0;
			events_q    <= '0;
			misses_q    <= '0;
			gap_peak_q  <= '0;
			busy_peak_q <= '0;
		end else if (cmd.update) begin
			last_q <= start_q;
			if (events_q != CNT_MAX) begin
				events_q <= events_q + 1'b1;
			end
			if (miss_c && (misses_q != CNT_MAX)) begin
				misses_q <= misses_q + 1'b1;
			end
			if (gap_ok_q && (gap_q > gap_peak_q)) begin
				gap_peak_q <= gap_q;
			end
			if (busy_ok_q && (busy_q > busy_peak_q)) begin
				busy_peak_q <= busy_q;
			end
		end
	end

	assign event_count  = events_q;
	assign miss_count   = misses_q;
	assign longest_gap  = gap_peak_q;
	assign longest_busy = busy_peak_q;

endmodule

>>> rtl/core/callback_timing_deadline_monitor.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------------
// input    | in_valid / in_ready  | start_time[63:0], finish_time[63:0]
// result   | out_valid/ out_ready | event_count, miss_count, longest_gap, longest_busy
// config   | cfg_valid/ cfg_ready | cfg_index[1:0], cfg_data[19:0]
//
// Each event passes from input transfer to result through these steps: capture, prepare,
// 46 steps of the bit-serial period divider, threshold, update.
// One event is in flight at a time; the next input is taken once the result is loaded.
// A result held by out_ready low stalls the update step and nothing earlier.
// Reset clears all statistics; frames_per_event resets to 256, sample_rate_hz to 48000.
module callback_timing_deadline_monitor import cbtdm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [TS_W-1:0]       start_time,
	input  logic [TS_W-1:0]       finish_time,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CNT_W-1:0]      event_count,
	output logic [CNT_W-1:0]      miss_count,
	output logic [TS_W-1:0]       longest_gap,
	output logic [TS_W-1:0]       longest_busy,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	cbtdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cbtdm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start_time   (start_time),
		.finish_time  (finish_time),
		.event_count  (event_count),
		.miss_count   (miss_count),
		.longest_gap  (longest_gap),
		.longest_busy (longest_busy)
	);

endmodule

>>> rtl/core/cbtdm_chk.sv
`include "callback_timing_deadline_monitor_macros.svh"

module cbtdm_chk import cbtdm_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [CNT_W-1:0] event_count,
	input logic [CNT_W-1:0] miss_count
);

	// a waiting result stays offered
	`CBTDM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// one event at a time: busy right after an input transfer
	`CBTDM_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)
	// a fresh result always counts at least one event
	`CBTDM_ASSERT(a_count_nonzero, $rose(out_valid) |-> (event_count != '0))
	// misses are only counted alongside events
	`CBTDM_ASSERT(a_miss_le_events, out_valid |-> (miss_count <= event_count))

endmodule

bind callback_timing_deadline_monitor cbtdm_chk u_cbtdm_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.event_count (event_count),
	.miss_count  (miss_count)
);
